// ----- hw/rtl/gnsm_pkg.sv -----
// shared types and constants of the greedy nearest shape match core
package gnsm_pkg;

   localparam int MAX_SHAPES_DEF = 32;
   localparam int MAX_OUT        = 32;

   localparam int SIZE_W    = 16;
   localparam int COORD_W   = 18;
   localparam int IDX_OUT_W = 5;
   localparam int RADIUS_W  = 8;
   localparam int R2_W      = 2 * RADIUS_W;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int D2_W      = SQ_W + 1;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd192;
   localparam logic [RADIUS_W-1:0] RADIUS_MIN   = 8'd64;
   localparam logic [RADIUS_W-1:0] RADIUS_MAX   = 8'd192;

   typedef struct packed {
      logic [SIZE_W-1:0]  size;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
   } shape_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic init;
      logic bscan_start;
      logic ascan_start;
      logic take_pair;
      logic flush;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_busy;
      logic bfound;
      logic pair_ok;
      logic pairs_full;
      logic slot_free;
      logic out_free;
   } status_type;

endpackage

// ----- hw/rtl/gnsm_ctrl.sv -----
// sequencer for loading, selection scans, pairing and result flush
module gnsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_shape,
   output logic                   req_ready,
   input  gnsm_pkg::status_type   status,
   output gnsm_pkg::cmd_type      cmd
);
   import gnsm_pkg::*;

   typedef enum logic [7:0] {
      S_LOAD   = 8'b0000_0001,
      S_INIT   = 8'b0000_0010,
      S_BSTART = 8'b0000_0100,
      S_BWAIT  = 8'b0000_1000,
      S_ASTART = 8'b0001_0000,
      S_AWAIT  = 8'b0010_0000,
      S_PAIR   = 8'b0100_0000,
      S_FLUSH  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_LOAD);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_shape) state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_BSTART;
         end
         S_BSTART: begin
            if (status.pairs_full) begin
               state_in = S_FLUSH;
            end else begin
               cmd.bscan_start = 1'b1;
               state_in        = S_BWAIT;
            end
         end
         S_BWAIT: begin
            if (!status.scan_busy) state_in = status.bfound ? S_ASTART : S_FLUSH;
         end
         S_ASTART: begin
            cmd.ascan_start = 1'b1;
            state_in        = S_AWAIT;
         end
         S_AWAIT: begin
            if (!status.scan_busy) state_in = status.pair_ok ? S_PAIR : S_BSTART;
         end
         S_PAIR: begin
            if (status.slot_free) begin
               cmd.take_pair = 1'b1;
               state_in      = S_BSTART;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/gnsm_dpath.sv -----
// shape stores, scan pipeline, best-candidate registers and result stage
module gnsm_dpath #(
   parameter int MAX_SHAPES = gnsm_pkg::MAX_SHAPES_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  gnsm_pkg::cmd_type                        cmd,
   output gnsm_pkg::status_type                     status,
   input  logic                                     req_side,
   input  logic [gnsm_pkg::SIZE_W-1:0]              req_shape_size,
   input  logic signed [gnsm_pkg::COORD_W-1:0]      req_center_x,
   input  logic signed [gnsm_pkg::COORD_W-1:0]      req_center_y,
   input  logic [gnsm_pkg::RADIUS_W-1:0]            radius,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_matched,
   output logic [gnsm_pkg::IDX_OUT_W-1:0]           rsp_before_index,
   output logic [gnsm_pkg::IDX_OUT_W-1:0]           rsp_after_index,
   output logic                                     rsp_overflowed,
   output logic                                     rsp_last_result
);
   import gnsm_pkg::*;

   localparam int IW  = $clog2(MAX_SHAPES);
   localparam int CW  = $clog2(MAX_SHAPES + 1);
   localparam int PCW = $clog2(MAX_OUT + 1);

   function automatic logic size_ratio_ok(input logic [SIZE_W-1:0] bsz,
                                          input logic [SIZE_W-1:0] asz);
      logic [SIZE_W+1:0] b3;
      logic [SIZE_W+1:0] a3;
      b3 = {2'b00, bsz} + {1'b0, bsz, 1'b0};
      a3 = {2'b00, asz} + {1'b0, asz, 1'b0};
      return ({2'b00, bsz} <= a3) && ({2'b00, asz} <= b3);
   endfunction

   // shape counts and overflow
   logic [CW-1:0] bcnt_ff, acnt_ff;
   logic          ovf_ff;
   logic          bfull, afull;
   shape_type     wr_shape;

   assign bfull    = (bcnt_ff == CW'(MAX_SHAPES));
   assign afull    = (acnt_ff == CW'(MAX_SHAPES));
   assign wr_shape = '{size: req_shape_size, cx: req_center_x, cy: req_center_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff <= '0;
         acnt_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.flush) begin
         bcnt_ff <= '0;
         acnt_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.load) begin
         if (!req_side) begin
            if (!bfull) bcnt_ff <= bcnt_ff + CW'(1);
            else        ovf_ff  <= 1'b1;
         end else begin
            if (!afull) acnt_ff <= acnt_ff + CW'(1);
            else        ovf_ff  <= 1'b1;
         end
      end
   end

   // scan issue
   logic          scan_act_ff, scan_side_ff;
   logic [CW-1:0] scan_cnt_ff;
   logic [CW-1:0] scan_limit;
   logic          issue;
   logic [IW-1:0] rd_addr;

   assign scan_limit = scan_side_ff ? acnt_ff : bcnt_ff;
   assign issue      = scan_act_ff && (scan_cnt_ff < scan_limit);
   assign rd_addr    = scan_cnt_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_act_ff  <= 1'b0;
         scan_side_ff <= 1'b0;
         scan_cnt_ff  <= '0;
      end else if (cmd.bscan_start || cmd.ascan_start) begin
         scan_act_ff  <= 1'b1;
         scan_side_ff <= cmd.ascan_start;
         scan_cnt_ff  <= '0;
      end else if (scan_act_ff) begin
         if (issue) scan_cnt_ff <= scan_cnt_ff + CW'(1);
         else       scan_act_ff <= 1'b0;
      end
   end

   // shape stores
   shape_type bmem_ff [MAX_SHAPES];
   shape_type amem_ff [MAX_SHAPES];
   shape_type brd_ff, ard_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && !req_side && !bfull) bmem_ff[bcnt_ff[IW-1:0]] <= wr_shape;
      if (issue && !scan_side_ff) brd_ff <= bmem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_side && !afull) amem_ff[acnt_ff[IW-1:0]] <= wr_shape;
      if (issue && scan_side_ff) ard_ff <= amem_ff[rd_addr];
   end

   logic          v1_ff, side1_ff;
   logic [IW-1:0] idx1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= issue;
      side1_ff <= scan_side_ff;
      idx1_ff  <= rd_addr;
   end

   // before selection: largest not yet handled, earliest on a tie
   logic [MAX_SHAPES-1:0] bdone_ff;
   logic                  bfound_ff;
   shape_type             bsel_ff;
   logic [IW-1:0]         bsel_idx_ff;
   logic                  b_take;

   assign b_take = v1_ff && !side1_ff && !bdone_ff[idx1_ff] &&
                   (!bfound_ff || (brd_ff.size > bsel_ff.size));

   always_ff @(posedge clock) begin
      if (reset) begin
         bfound_ff <= 1'b0;
      end else if (cmd.bscan_start) begin
         bfound_ff <= 1'b0;
      end else if (b_take) begin
         bfound_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (b_take) begin
         bsel_ff     <= brd_ff;
         bsel_idx_ff <= idx1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bdone_ff <= '0;
      end else if (cmd.init) begin
         bdone_ff <= '0;
      end else if (cmd.ascan_start) begin
         bdone_ff[bsel_idx_ff] <= 1'b1;
      end
   end

   // after scan, stage 2: differences and eligibility
   logic [MAX_SHAPES-1:0]     taken_ff;
   logic signed [DIFF_W-1:0]  dx_in, dy_in, dx2_ff, dy2_ff;
   logic                      v2_ff, ok2_ff;
   logic [IW-1:0]             idx2_ff;
   logic [SIZE_W-1:0]         size2_ff;

   assign dx_in = {bsel_ff.cx[COORD_W-1], bsel_ff.cx} - {ard_ff.cx[COORD_W-1], ard_ff.cx};
   assign dy_in = {bsel_ff.cy[COORD_W-1], bsel_ff.cy} - {ard_ff.cy[COORD_W-1], ard_ff.cy};

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff && side1_ff;
      dx2_ff   <= dx_in;
      dy2_ff   <= dy_in;
      ok2_ff   <= !taken_ff[idx1_ff] && size_ratio_ok(bsel_ff.size, ard_ff.size);
      idx2_ff  <= idx1_ff;
      size2_ff <= ard_ff.size;
   end

   // stage 3: squares
   logic signed [2*DIFF_W-1:0] px, py;
   logic [SQ_W-1:0]            sqx_ff, sqy_ff;
   logic                       v3_ff, ok3_ff;
   logic [IW-1:0]              idx3_ff;
   logic [SIZE_W-1:0]          size3_ff;

   assign px = dx2_ff * dx2_ff;
   assign py = dy2_ff * dy2_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      sqx_ff   <= px[SQ_W-1:0];
      sqy_ff   <= py[SQ_W-1:0];
      ok3_ff   <= ok2_ff;
      idx3_ff  <= idx2_ff;
      size3_ff <= size2_ff;
   end

   // stage 4: nearest, ties to larger size then earlier arrival
   logic [D2_W-1:0]   d2;
   logic              a_take;
   logic              afound_ff;
   logic [D2_W-1:0]   abest_d2_ff;
   logic [SIZE_W-1:0] abest_size_ff;
   logic [IW-1:0]     abest_idx_ff;

   assign d2     = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign a_take = v3_ff && ok3_ff &&
                   (!afound_ff || (d2 < abest_d2_ff) ||
                    ((d2 == abest_d2_ff) && (size3_ff > abest_size_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         afound_ff <= 1'b0;
      end else if (cmd.ascan_start) begin
         afound_ff <= 1'b0;
      end else if (a_take) begin
         afound_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         abest_d2_ff   <= d2;
         abest_size_ff <= size3_ff;
         abest_idx_ff  <= idx3_ff;
      end
   end

   // squared radius, set up at the start of matching
   logic [R2_W-1:0] r2_ff;

   always_ff @(posedge clock) begin
      if (cmd.init) r2_ff <= R2_W'(radius) * R2_W'(radius);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
      end else if (cmd.init) begin
         taken_ff <= '0;
      end else if (cmd.take_pair) begin
         taken_ff[abest_idx_ff] <= 1'b1;
      end
   end

   // pending pair and pair count
   logic           pend_valid_ff;
   logic [IW-1:0]  pend_b_ff, pend_a_ff;
   logic [PCW-1:0] pair_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pair_cnt_ff   <= '0;
      end else if (cmd.init || cmd.flush) begin
         pend_valid_ff <= 1'b0;
         pair_cnt_ff   <= '0;
      end else if (cmd.take_pair) begin
         pend_valid_ff <= 1'b1;
         pair_cnt_ff   <= pair_cnt_ff + PCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_pair) begin
         pend_b_ff <= bsel_idx_ff;
         pend_a_ff <= abest_idx_ff;
      end
   end

   // result register
   logic [IW+IDX_OUT_W-1:0] pend_b_ext, pend_a_ext;
   logic                    out_free, out_load;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_matched_ff, rsp_ovf_ff, rsp_last_ff;
   logic [IDX_OUT_W-1:0]    rsp_b_ff, rsp_a_ff;

   assign pend_b_ext   = {{IDX_OUT_W{1'b0}}, pend_b_ff};
   assign pend_a_ext   = {{IDX_OUT_W{1'b0}}, pend_a_ff};
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign out_load     = cmd.flush || (cmd.take_pair && pend_valid_ff);
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_matched_ff <= pend_valid_ff;
         rsp_b_ff       <= pend_valid_ff ? pend_b_ext[IDX_OUT_W-1:0] : '0;
         rsp_a_ff       <= pend_valid_ff ? pend_a_ext[IDX_OUT_W-1:0] : '0;
         rsp_ovf_ff     <= ovf_ff;
         rsp_last_ff    <= cmd.flush;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_matched      = rsp_matched_ff;
   assign rsp_before_index = rsp_b_ff;
   assign rsp_after_index  = rsp_a_ff;
   assign rsp_overflowed   = rsp_ovf_ff;
   assign rsp_last_result  = rsp_last_ff;

   always_comb begin
      status.scan_busy  = scan_act_ff || v1_ff || v2_ff || v3_ff;
      status.bfound     = bfound_ff;
      status.pair_ok    = afound_ff && (abest_d2_ff <= D2_W'(r2_ff));
      status.pairs_full = (pair_cnt_ff == PCW'(MAX_OUT));
      status.slot_free  = !pend_valid_ff || out_free;
      status.out_free   = out_free;
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_pair && pend_valid_ff) |-> out_free)
      else $error("pending pair pushed into a full result register");

   a_scan_not_overlapped: assert property (@(posedge clock) disable iff (reset)
      (cmd.bscan_start || cmd.ascan_start) |-> !status.scan_busy)
      else $error("scan started while another is in flight");

   a_pick_untaken: assert property (@(posedge clock) disable iff (reset)
      cmd.take_pair |-> (afound_ff && !taken_ff[abest_idx_ff]))
      else $error("after shape paired twice");

   a_pair_limit: assert property (@(posedge clock) disable iff (reset)
      pair_cnt_ff <= PCW'(MAX_OUT))
      else $error("pair count beyond result limit");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (bcnt_ff == '0 && acnt_ff == '0 && !pend_valid_ff && !ovf_ff))
      else $error("run state left over after flush");

endmodule

// ----- hw/rtl/greedy_nearest_shape_match_core.sv -----
// top level of the greedy nearest shape match core
//
// usage
//   req channel: one item per shape, side 0 = before, side 1 = after, with its
//   cell count and center (cells times 64). loading takes one item per cycle.
//   the item with last_shape set is stored too and then matching starts;
//   req_ready stays low until the run's final result is in the rsp register.
//   csr channel: writes the match radius (cells times 64), clamped to 64..192
//   when matching starts; write it only while the core is idle.
//   rsp channel: one item per accepted pair in the order found, or a single
//   item with matched low for a run with no pair; last_result marks the end.
// timing
//   each before shape costs one selection scan over the before store and one
//   scan over the after store through a four-stage read, subtract, square,
//   compare pipe, plus a pair step for each accepted pair, then a closing
//   selection scan unless the pair limit is reached; one store read per cycle.
// reset
//   radius returns to 192, both shape counts and the overflow flag clear.
//   no store clearing pass is needed. a stalled rsp holds its item; matching
//   runs ahead until the next pair has to be handed over.
module greedy_nearest_shape_match_core #(
   parameter int MAX_SHAPES = gnsm_pkg::MAX_SHAPES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input shapes
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_side,
   input  logic [gnsm_pkg::SIZE_W-1:0]           req_shape_size,
   input  logic signed [gnsm_pkg::COORD_W-1:0]   req_center_x,
   input  logic signed [gnsm_pkg::COORD_W-1:0]   req_center_y,
   input  logic                                  req_last_shape,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_matched,
   output logic [gnsm_pkg::IDX_OUT_W-1:0]        rsp_before_index,
   output logic [gnsm_pkg::IDX_OUT_W-1:0]        rsp_after_index,
   output logic                                  rsp_overflowed,
   output logic                                  rsp_last_result,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gnsm_pkg::RADIUS_W-1:0]         csr_match_radius
);
   import gnsm_pkg::*;

   // match radius register, always ready; writes are to come only when idle, the core does not enforce this
   logic [RADIUS_W-1:0] radius_ff;
   logic [RADIUS_W-1:0] radius_clamped;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_match_radius;
      end
   end

   // clamp to one through three cells
   always_comb begin
      if (radius_ff < RADIUS_MIN)      radius_clamped = RADIUS_MIN;
      else if (radius_ff > RADIUS_MAX) radius_clamped = RADIUS_MAX;
      else                             radius_clamped = radius_ff;
   end

   cmd_type    cmd;
   status_type status;

   // sequencer
   gnsm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_shape (req_last_shape),
      .req_ready      (req_ready),
      .status         (status),
      .cmd            (cmd)
   );

   // stores, scan pipe and result register
   gnsm_dpath #(
      .MAX_SHAPES (MAX_SHAPES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_side         (req_side),
      .req_shape_size   (req_shape_size),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .radius           (radius_clamped),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_matched      (rsp_matched),
      .rsp_before_index (rsp_before_index),
      .rsp_after_index  (rsp_after_index),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

// ----- dv/tb_top.sv -----
// greedy nearest shape match core testbench: directed and random runs checked against a predictor
`timescale 1ns / 1ps

module tb_top;
   import gnsm_pkg::*;

   localparam logic SIDE_BEFORE = 1'b0;
   localparam logic SIDE_AFTER  = 1'b1;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int SETTLE_CYCLES    = 16;
   localparam int TAIL_CYCLES      = 100;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS      = 80;
   localparam int NUM_PHASES       = 6;

   typedef struct packed {
      logic                      side;
      logic [SIZE_W-1:0]         size;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic                      last_shape;
   } shape_item_type;

   typedef struct packed {
      logic                 matched;
      logic [IDX_OUT_W-1:0] before_index;
      logic [IDX_OUT_W-1:0] after_index;
      logic                 overflowed;
      logic                 last_result;
   } pair_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_side = 1'b0;
   logic [SIZE_W-1:0]         req_shape_size = '0;
   logic signed [COORD_W-1:0] req_center_x = '0;
   logic signed [COORD_W-1:0] req_center_y = '0;
   logic                      req_last_shape = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_matched;
   logic [IDX_OUT_W-1:0]      rsp_before_index;
   logic [IDX_OUT_W-1:0]      rsp_after_index;
   logic                      rsp_overflowed;
   logic                      rsp_last_result;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [RADIUS_W-1:0]       csr_match_radius = RADIUS_RESET;

   greedy_nearest_shape_match_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_side         (req_side),
      .req_shape_size   (req_shape_size),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_last_shape   (req_last_shape),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_matched      (rsp_matched),
      .rsp_before_index (rsp_before_index),
      .rsp_after_index  (rsp_after_index),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_last_result  (rsp_last_result),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_match_radius (csr_match_radius)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // shapes waiting to be driven, and pairs the core still owes us
   shape_item_type shape_q[$];
   pair_type       pair_q[$];

   int cycle_count    = 0;
   int items_taken    = 0;
   int mismatch_count = 0;

   // predictor copy of the core state
   logic [SIZE_W-1:0]         size_mem [2][MAX_SHAPES_DEF];
   logic signed [COORD_W-1:0] cx_mem   [2][MAX_SHAPES_DEF];
   logic signed [COORD_W-1:0] cy_mem   [2][MAX_SHAPES_DEF];
   int                        stored_count [2] = '{0, 0};
   logic                      dropped_any = 1'b0;
   logic [RADIUS_W-1:0]       radius_setting = RADIUS_RESET;

   // stable descending order by size, holding arrival positions
   function automatic void rank_by_size(input int side, input int n,
                                        output int ord [MAX_SHAPES_DEF]);
      int j;
      for (int i = 0; i < n; i++) begin
         j = i;
         while (j > 0 && size_mem[side][ord[j-1]] < size_mem[side][i]) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = i;
      end
   endfunction

   // store one accepted shape; on the run's final shape work out every pair
   function automatic void absorb_shape(input shape_item_type it);
      int       side, nb, na, b, a, bsz, asz, best_pos;
      int       order_b [MAX_SHAPES_DEF];
      int       order_a [MAX_SHAPES_DEF];
      bit       taken [MAX_SHAPES_DEF];
      bit       found;
      longint   radius, r2, dx, dy, d2, best;
      pair_type p;
      pair_type run_pairs[$];
      side = int'(it.side);
      if (stored_count[side] < MAX_SHAPES_DEF) begin
         size_mem[side][stored_count[side]] = it.size;
         cx_mem[side][stored_count[side]]   = it.cx;
         cy_mem[side][stored_count[side]]   = it.cy;
         stored_count[side]++;
      end else begin
         dropped_any = 1'b1;
      end
      if (!it.last_shape) return;

      nb = stored_count[SIDE_BEFORE];
      na = stored_count[SIDE_AFTER];
      rank_by_size(SIDE_BEFORE, nb, order_b);
      rank_by_size(SIDE_AFTER, na, order_a);
      foreach (taken[i]) taken[i] = 1'b0;

      radius = radius_setting;
      if (radius < RADIUS_MIN) radius = RADIUS_MIN;
      if (radius > RADIUS_MAX) radius = RADIUS_MAX;
      r2 = radius * radius;

      for (int bi = 0; bi < nb && run_pairs.size() < MAX_OUT; bi++) begin
         b        = order_b[bi];
         bsz      = size_mem[SIDE_BEFORE][b];
         found    = 1'b0;
         best     = 0;
         best_pos = 0;
         for (int ai = 0; ai < na; ai++) begin
            if (taken[ai]) continue;
            a   = order_a[ai];
            asz = size_mem[SIDE_AFTER][a];
            // size ratio must lie within 1/3 .. 3
            if (bsz > 3 * asz || asz > 3 * bsz) continue;
            dx = longint'(cx_mem[SIDE_BEFORE][b]) - longint'(cx_mem[SIDE_AFTER][a]);
            dy = longint'(cy_mem[SIDE_BEFORE][b]) - longint'(cy_mem[SIDE_AFTER][a]);
            d2 = dx * dx + dy * dy;
            // strict compare keeps the earliest on a tie
            if (!found || d2 < best) begin
               found    = 1'b1;
               best     = d2;
               best_pos = ai;
            end
         end
         if (!found || best > r2) continue;
         taken[best_pos]  = 1'b1;
         p.matched        = 1'b1;
         p.before_index   = IDX_OUT_W'(b);
         p.after_index    = IDX_OUT_W'(order_a[best_pos]);
         p.overflowed     = dropped_any;
         p.last_result    = 1'b0;
         run_pairs        = {run_pairs, p};
      end

      if (run_pairs.size() == 0) begin
         p             = '0;
         p.overflowed  = dropped_any;
         p.last_result = 1'b1;
         pair_q        = {pair_q, p};
      end else begin
         foreach (run_pairs[k]) begin
            p             = run_pairs[k];
            p.last_result = (k == run_pairs.size() - 1);
            pair_q        = {pair_q, p};
         end
      end
      stored_count[SIDE_BEFORE] = 0;
      stored_count[SIDE_AFTER]  = 0;
      dropped_any               = 1'b0;
   endfunction

   function automatic void check_pair();
      pair_type got, want;
      got.matched      = rsp_matched;
      got.before_index = rsp_before_index;
      got.after_index  = rsp_after_index;
      got.overflowed   = rsp_overflowed;
      got.last_result  = rsp_last_result;
      if (pair_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: result with none expected: m=%0d b=%0d a=%0d ovf=%0d last=%0d",
                     $time, got.matched, got.before_index, got.after_index,
                     got.overflowed, got.last_result);
      end else begin
         want = pair_q.pop_front();
         if (got.matched !== want.matched || got.before_index !== want.before_index ||
             got.after_index !== want.after_index || got.overflowed !== want.overflowed ||
             got.last_result !== want.last_result) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: exp m=%0d b=%0d a=%0d ovf=%0d last=%0d, got m=%0d b=%0d a=%0d ovf=%0d last=%0d",
                        $time, want.matched, want.before_index, want.after_index,
                        want.overflowed, want.last_result, got.matched, got.before_index,
                        got.after_index, got.overflowed, got.last_result);
         end
      end
   endfunction

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin : shape_driver
      bit             took;
      shape_item_type cur_item;
      int             burst_left;
      int             gap_left;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 4;
         gap_left   = 0;
      end else begin
         took = req_valid && req_ready;
         if (took) begin
            absorb_shape(cur_item);
            items_taken <= items_taken + 1;
         end
         if (!req_valid || took) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (shape_q.size() != 0) begin
               cur_item = shape_q.pop_front();
               req_side       <= cur_item.side;
               req_shape_size <= cur_item.size;
               req_center_x   <= cur_item.cx;
               req_center_y   <= cur_item.cy;
               req_last_shape <= cur_item.last_shape;
               req_valid      <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(1, 8);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: rotating ready mask, plus two long hold-offs mid run
   always @(posedge clock) begin : pair_monitor
      logic [15:0] ready_mask;
      int          mask_pos;
      int          hold_left;
      int          holds_done;
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_mask = '1;
         mask_pos   = 0;
         hold_left  = 0;
         holds_done = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_pair();
         if (hold_left == 0 && rsp_valid && holds_done < 2 &&
             items_taken >= (holds_done == 0 ? 100 : 300)) begin
            hold_left = LONG_HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ready_mask[mask_pos];
            if (mask_pos == 15) begin
               mask_pos = 0;
               case ($urandom_range(0, 3))
                  0:       ready_mask = '1;
                  1:       ready_mask = 16'($urandom);
                  2:       ready_mask = 16'($urandom | $urandom);
                  default: ready_mask = 16'($urandom & $urandom);
               endcase
            end else begin
               mask_pos++;
            end
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic logic [SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r <= 4) return SIZE_W'($urandom);
      return SIZE_W'($urandom_range(1, 300));
   endfunction

   function automatic logic signed [COORD_W-1:0] any_coord();
      return COORD_W'($urandom);
   endfunction

   function automatic int jitter(input int spread);
      return int'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   task automatic queue_shape(input logic side, input int size, input int cx, input int cy,
                              input logic last);
      shape_item_type it;
      it.side       = side;
      it.size       = SIZE_W'(size);
      it.cx         = COORD_W'(cx);
      it.cy         = COORD_W'(cy);
      it.last_shape = last;
      shape_q       = {shape_q, it};
   endtask

   // one run: mostly before/after sets that resemble each other, some noise
   task automatic queue_random_run(inout int items_queued);
      int             kind, nb, na, n, spread, seed, sz, base_x, base_y;
      bit             big, cluster;
      shape_item_type it;
      shape_item_type befores[$], afters[$], run[$];
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         big     = ($urandom_range(0, 11) == 0);
         nb      = big ? $urandom_range(26, 36) : $urandom_range(1, 7);
         na      = big ? $urandom_range(26, 36) : $urandom_range(0, 8);
         cluster = $urandom_range(0, 1);
         spread  = $urandom_range(16, 220);
         base_x  = int'(any_coord());
         base_y  = int'(any_coord());
         it.last_shape = 1'b0;
         for (int k = 0; k < nb; k++) begin
            it.side = SIDE_BEFORE;
            it.size = pick_size();
            it.cx   = cluster ? COORD_W'(base_x + jitter(400)) : any_coord();
            it.cy   = cluster ? COORD_W'(base_y + jitter(400)) : any_coord();
            befores = {befores, it};
         end
         for (int k = 0; k < na; k++) begin
            seed = (big && k < nb) ? k : $urandom_range(0, nb - 1);
            // ratio from 1/4 to 4, so some fall outside the accepted band
            sz   = int'(befores[seed].size) * $urandom_range(1, 4) / $urandom_range(1, 4);
            if (sz > 65535) sz = 65535;
            it.side = SIDE_AFTER;
            it.size = SIZE_W'(sz);
            it.cx   = COORD_W'(int'(befores[seed].cx) + jitter(spread));
            it.cy   = COORD_W'(int'(befores[seed].cy) + jitter(spread));
            afters  = {afters, it};
         end
         while (befores.size() != 0 || afters.size() != 0) begin
            if (afters.size() == 0 || (befores.size() != 0 && $urandom_range(0, 1)))
               run = {run, befores.pop_front()};
            else
               run = {run, afters.pop_front()};
         end
      end else begin
         // noise mixes both sides; a broken run fills only one side
         n  = $urandom_range(1, 6);
         sz = $urandom_range(0, 1);
         for (int k = 0; k < n; k++) begin
            it.side       = (kind == 9) ? sz[0] : 1'($urandom);
            it.size       = pick_size();
            it.cx         = any_coord();
            it.cy         = any_coord();
            it.last_shape = 1'b0;
            run           = {run, it};
         end
      end
      foreach (run[i]) begin
         it            = run[i];
         it.last_shape = (i == run.size() - 1);
         shape_q       = {shape_q, it};
      end
      items_queued += run.size();
   endtask

   // all items driven and every owed pair received, then let the core settle
   task automatic wait_idle();
      do @(negedge clock);
      while (shape_q.size() != 0 || req_valid || pair_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radius(input logic [RADIUS_W-1:0] value);
      @(posedge clock);
      csr_match_radius <= value;
      csr_valid        <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      radius_setting = value;
      csr_valid      <= 1'b0;
   endtask

   initial begin
      logic [RADIUS_W-1:0] phase_radius [NUM_PHASES];
      int                  items_queued;
      phase_radius = '{8'd128, 8'd64, 8'd255, 8'd63, 8'd192, 8'd0};
      phase_radius[NUM_PHASES-1] = RADIUS_W'($urandom_range(0, 255));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed runs at the reset radius of 192
      @(negedge clock);
      queue_shape(SIDE_BEFORE, 0, 0, 0, 1'b0);
      queue_shape(SIDE_BEFORE, 65535, 131071, 131071, 1'b0);
      queue_shape(SIDE_BEFORE, 100, -131072, -131072, 1'b0);
      queue_shape(SIDE_BEFORE, 50, 1000, 1000, 1'b0);
      queue_shape(SIDE_AFTER, 0, 10, -10, 1'b0);            // zero size pairs only with zero
      queue_shape(SIDE_AFTER, 65535, 130879, 131071, 1'b0); // distance exactly at the radius
      queue_shape(SIDE_AFTER, 301, -131072, -131072, 1'b0); // nearer but ratio just over 3
      queue_shape(SIDE_AFTER, 300, -131008, -131072, 1'b0); // ratio exactly 3
      queue_shape(SIDE_AFTER, 50, 1064, 1000, 1'b0);        // tie in distance, earlier wins
      queue_shape(SIDE_AFTER, 50, 936, 1000, 1'b1);
      queue_shape(SIDE_BEFORE, 77, 5, 5, 1'b1);             // lone before shape, no pair
      queue_shape(SIDE_AFTER, 77, -5, -5, 1'b1);            // lone after shape, no pair
      queue_shape(SIDE_BEFORE, 20, 0, 0, 1'b0);
      queue_shape(SIDE_AFTER, 20, 193, 0, 1'b1);            // one unit beyond the radius
      wait_idle();

      // radius below range clamps to 64
      write_radius(8'd0);
      @(negedge clock);
      queue_shape(SIDE_BEFORE, 10, 0, 0, 1'b0);
      queue_shape(SIDE_AFTER, 10, 65, 0, 1'b1);
      queue_shape(SIDE_BEFORE, 10, 0, 0, 1'b0);
      queue_shape(SIDE_AFTER, 10, 0, -64, 1'b1);
      wait_idle();

      // radius above range clamps to 192
      write_radius(8'd255);
      @(negedge clock);
      queue_shape(SIDE_BEFORE, 30, -1000, -1000, 1'b0);
      queue_shape(SIDE_AFTER, 30, -800, -1000, 1'b1);
      wait_idle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_radius(phase_radius[ph]);
         @(negedge clock);
         items_queued = 0;
         while (items_queued < PHASE_ITEMS) queue_random_run(items_queued);
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
